@@ design/averaged_temperature_fan_level_unit_assert.svh @@
// ============================================================================
// Assertion macros for the averaged temperature fan level unit
// Shared wrappers for concurrent checks on the unit's ports.
// ============================================================================
`ifndef AVERAGED_TEMPERATURE_FAN_LEVEL_UNIT_ASSERT_SVH
`define AVERAGED_TEMPERATURE_FAN_LEVEL_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define AVTF_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("averaged temperature fan level unit: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define AVTF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("averaged temperature fan level unit: next-cycle check failed");

`endif

@@ design/avtf_pkg.sv @@
// ============================================================================
// avtf_pkg
// Widths, register indexes and shared types of the averaged temperature
// fan level unit.
// ============================================================================
package avtf_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int THRESH_W    = 16;
    localparam int LIMIT_W     = 32;
    localparam int LIMIT_REGS  = 5;
    localparam int LEVEL_W     = 3;
    localparam int MASK_W      = 5;
    localparam int AVG_W       = 16;
    localparam int CFG_INDEX_W = 3;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 24;

    localparam int DEFAULT_HISTORY_DEPTH = 5;
    localparam int DEFAULT_LEVEL_COUNT   = 6;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_LEVEL1_LIMITS = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_LEVEL2_LIMITS = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_LEVEL3_LIMITS = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_LEVEL4_LIMITS = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_LEVEL5_LIMITS = 3'd4;

    // Status reported by the serial arithmetic units.
    typedef struct packed {
        logic busy;
        logic done;
    } avtf_unit_status_t;

endpackage

@@ design/averaged_temperature_fan_level_unit.sv @@
// ============================================================================
// averaged_temperature_fan_level_unit
// Moving average of temperature samples driving a multi-level fan control
// with hysteresis.
// ============================================================================
// Usage: one signed temperature sample (1/16 C) enters per transaction on s_;
// each yields one result transaction on m_ with the fan level, the stage mask
// and the averaged temperature. Thresholds are written on the cfg channel,
// which is always ready; writes are expected only while the unit is idle, and
// indexes past the fifth register are ignored.
// Timing: the sample is stored at acceptance. The average comes from a
// bit-serial divider. In parallel, each level test is a shift-and-add
// multiply of the threshold by the fill count, then a compare; a loop
// already at its end (top level or zero) runs no test. The result is loaded
// into the output register once the divider and both loops are done.
// Only one sample is in work; s_tready is high only while the unit waits for
// a sample, so a new sample is taken only after the result of the last one
// has gone into the output register.
// Stalls: the result sits in an output register, so the next sample is taken
// while it waits; a finished result that finds that register still full
// waits until m_tready frees it.
// Reset: clears the history write position, the fill count, the sum, the level
// and the threshold registers; no result is pending after reset.
// ============================================================================
module averaged_temperature_fan_level_unit #(
    parameter int HISTORY_DEPTH = avtf_pkg::DEFAULT_HISTORY_DEPTH,
    parameter int LEVEL_COUNT   = avtf_pkg::DEFAULT_LEVEL_COUNT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // Sample channel. s_tdata: [15:0] temperature_sample.
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [avtf_pkg::IN_TDATA_W-1:0]     s_tdata,
    // Result channel. m_tdata: [2:0] fan level, [7:3] fan_stage_mask,
    // [23:8] average_temperature.
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [avtf_pkg::OUT_TDATA_W-1:0]    m_tdata,
    // Configuration write channel.
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [avtf_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [avtf_pkg::LIMIT_W-1:0]        cfg_data
);
    import avtf_pkg::*;

    // Sum of up to HISTORY_DEPTH 16-bit samples, and threshold times count.
    localparam int CNT_W     = $clog2(HISTORY_DEPTH + 1);
    localparam int SUM_W     = SAMPLE_W + $clog2(HISTORY_DEPTH);
    localparam int PROD_W    = THRESH_W + CNT_W;
    // Highest level that has a threshold register.
    localparam int TOP_LEVEL = (LEVEL_COUNT - 1 > LIMIT_REGS) ? LIMIT_REGS : LEVEL_COUNT - 1;
    localparam int LIDX_W    = $clog2(LIMIT_REGS);

    typedef enum logic [6:0] {
        S_IDLE       = 7'b0000001,
        S_START      = 7'b0000010,
        S_CLIMB      = 7'b0000100,
        S_CLIMB_WAIT = 7'b0001000,
        S_DROP       = 7'b0010000,
        S_DROP_WAIT  = 7'b0100000,
        S_FINISH     = 7'b1000000
    } state_t;

    state_t                     state_reg;
    state_t                     state_next;
    logic [LEVEL_W-1:0]         level_reg;
    logic [LEVEL_W-1:0]         level_next;
    logic [LEVEL_W-1:0]         cur_level_reg;
    logic [LEVEL_W-1:0]         cur_level_next;
    logic [LIMIT_W-1:0]         limit_reg [LIMIT_REGS];
    logic                       m_tvalid_reg;
    logic                       m_tvalid_next;
    logic [OUT_TDATA_W-1:0]     m_tdata_reg;

    logic                       in_accept;
    logic                       load_out;
    logic signed [SUM_W-1:0]    sum;
    logic        [CNT_W-1:0]    count;
    logic signed [PROD_W-1:0]   sum_ext;
    logic signed [PROD_W-1:0]   product;
    logic signed [AVG_W-1:0]    average;
    avtf_unit_status_t          mult_status;
    avtf_unit_status_t          div_status;
    logic                       mult_start;
    logic                       div_start;
    logic [LEVEL_W-1:0]         thresh_level;
    logic [LIMIT_W-1:0]         limit_sel;
    logic signed [THRESH_W-1:0] thresh;
    logic [MASK_W-1:0]          stage_mask;

    assign s_tready  = (state_reg == S_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    avtf_history #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .SUM_W         (SUM_W),
        .CNT_W         (CNT_W)
    ) u_history (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (in_accept),
        .sample (s_tdata[SAMPLE_W-1:0]),
        .sum    (sum),
        .count  (count)
    );

    // Climbing tests the on threshold of the next level, which lives in the
    // register indexed by the current level; dropping tests the off threshold
    // of the current level.
    assign thresh_level = (state_reg == S_CLIMB) ? level_reg : level_reg - 1'b1;
    assign limit_sel    = (thresh_level < LEVEL_W'(LIMIT_REGS))
                        ? limit_reg[thresh_level[LIDX_W-1:0]] : '0;
    assign thresh       = (state_reg == S_CLIMB) ? limit_sel[LIMIT_W-1:THRESH_W]
                                                 : limit_sel[THRESH_W-1:0];

    avtf_serial_mult #(
        .CNT_W  (CNT_W),
        .PROD_W (PROD_W)
    ) u_mult (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (mult_start),
        .multiplicand (thresh),
        .multiplier   (count),
        .product      (product),
        .status       (mult_status)
    );

    avtf_serial_div #(
        .SUM_W (SUM_W),
        .CNT_W (CNT_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum),
        .divisor  (count),
        .quotient (average),
        .status   (div_status)
    );

    // Exact comparison of the mean against a threshold: sum against T * count.
    assign sum_ext = PROD_W'(sum);

    always_comb
    begin
        state_next     = state_reg;
        level_next     = level_reg;
        cur_level_next = cur_level_reg;
        mult_start     = 1'b0;
        div_start      = 1'b0;
        load_out       = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    level_next = cur_level_reg;
                    state_next = S_START;
                end
            end
            S_START:
            begin
                div_start  = 1'b1;
                state_next = S_CLIMB;
            end
            S_CLIMB:
            begin
                if (level_reg < LEVEL_W'(TOP_LEVEL))
                begin
                    mult_start = 1'b1;
                    state_next = S_CLIMB_WAIT;
                end
                else
                begin
                    state_next = S_DROP;
                end
            end
            S_CLIMB_WAIT:
            begin
                if (mult_status.done)
                begin
                    if (sum_ext > product)
                    begin
                        level_next = level_reg + 1'b1;
                        state_next = S_CLIMB;
                    end
                    else
                    begin
                        state_next = S_DROP;
                    end
                end
            end
            S_DROP:
            begin
                if (level_reg != '0)
                begin
                    mult_start = 1'b1;
                    state_next = S_DROP_WAIT;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_DROP_WAIT:
            begin
                if (mult_status.done)
                begin
                    if (sum_ext < product)
                    begin
                        level_next = level_reg - 1'b1;
                        state_next = S_DROP;
                    end
                    else
                    begin
                        state_next = S_FINISH;
                    end
                end
            end
            S_FINISH:
            begin
                if (div_status.done && (!m_tvalid_reg || m_tready))
                begin
                    load_out       = 1'b1;
                    cur_level_next = level_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Stage i runs when i is below the level.
    always_comb
    begin
        for (int i = 0; i < MASK_W; i++)
        begin
            stage_mask[i] = (LEVEL_W'(i) < level_reg);
        end
    end

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        if (load_out)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            level_reg     <= '0;
            cur_level_reg <= '0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            level_reg     <= level_next;
            cur_level_reg <= cur_level_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            m_tdata_reg <= {average, stage_mask, level_reg};
        end
    end

    // Threshold registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LIMIT_REGS; i++)
            begin
                limit_reg[i] <= '0;
            end
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_LEVEL1_LIMITS: limit_reg[0] <= cfg_data;
                REG_LEVEL2_LIMITS: limit_reg[1] <= cfg_data;
                REG_LEVEL3_LIMITS: limit_reg[2] <= cfg_data;
                REG_LEVEL4_LIMITS: limit_reg[3] <= cfg_data;
                REG_LEVEL5_LIMITS: limit_reg[4] <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

@@ design/avtf_history.sv @@
// ============================================================================
// avtf_history
// Sample ring with write position, fill count and running sum.
// ============================================================================
module avtf_history #(
    parameter int HISTORY_DEPTH = avtf_pkg::DEFAULT_HISTORY_DEPTH,
    parameter int SUM_W         = 19,
    parameter int CNT_W         = 3
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    input  logic signed [avtf_pkg::SAMPLE_W-1:0] sample,
    output logic signed [SUM_W-1:0]             sum,
    output logic        [CNT_W-1:0]             count
);
    import avtf_pkg::*;

    localparam int POS_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;

    logic signed [SAMPLE_W-1:0] ring_reg [HISTORY_DEPTH];
    logic        [POS_W-1:0]    pos_reg;
    logic        [POS_W-1:0]    pos_next;
    logic        [CNT_W-1:0]    filled_reg;
    logic        [CNT_W-1:0]    filled_next;
    logic signed [SUM_W-1:0]    sum_reg;
    logic signed [SUM_W-1:0]    sum_next;
    logic signed [SAMPLE_W-1:0] oldest;
    logic                       full;

    assign full   = (filled_reg == CNT_W'(HISTORY_DEPTH));
    assign oldest = ring_reg[pos_reg];

    always_comb
    begin
        pos_next    = pos_reg;
        filled_next = filled_reg;
        sum_next    = sum_reg;
        if (push)
        begin
            if (pos_reg == POS_W'(HISTORY_DEPTH - 1))
            begin
                pos_next = '0;
            end
            else
            begin
                pos_next = pos_reg + 1'b1;
            end
            if (full)
            begin
                sum_next = sum_reg + SUM_W'(sample) - SUM_W'(oldest);
            end
            else
            begin
                filled_next = filled_reg + 1'b1;
                sum_next    = sum_reg + SUM_W'(sample);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            filled_reg <= '0;
            sum_reg    <= '0;
        end
        else
        begin
            pos_reg    <= pos_next;
            filled_reg <= filled_next;
            sum_reg    <= sum_next;
        end
    end

    // The ring holds payload only; entries are read once the ring is full.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ring_reg[pos_reg] <= sample;
        end
    end

    assign sum   = sum_reg;
    assign count = filled_reg;

endmodule

@@ design/avtf_serial_mult.sv @@
// ============================================================================
// avtf_serial_mult
// Shift-and-add multiplier: threshold times fill count, one count bit a cycle.
// ============================================================================
module avtf_serial_mult #(
    parameter int CNT_W  = 3,
    parameter int PROD_W = 19
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic signed [avtf_pkg::THRESH_W-1:0] multiplicand,
    input  logic        [CNT_W-1:0]              multiplier,
    output logic signed [PROD_W-1:0]             product,
    output avtf_pkg::avtf_unit_status_t          status
);
    import avtf_pkg::*;

    localparam int STEP_W = $clog2(CNT_W + 1);

    logic signed [PROD_W-1:0] acc_reg;
    logic signed [PROD_W-1:0] mcand_reg;
    logic        [CNT_W-1:0]  mplier_reg;
    logic        [STEP_W-1:0] step_reg;
    logic                     busy_reg;
    logic                     done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            step_reg <= STEP_W'(CNT_W);
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg - 1'b1;
            if (step_reg == STEP_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg    <= '0;
            mcand_reg  <= PROD_W'(multiplicand);
            mplier_reg <= multiplier;
        end
        else if (busy_reg)
        begin
            if (mplier_reg[0])
            begin
                acc_reg <= acc_reg + mcand_reg;
            end
            mcand_reg  <= mcand_reg <<< 1;
            mplier_reg <= mplier_reg >> 1;
        end
    end

    assign product     = acc_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

@@ design/avtf_serial_div.sv @@
// ============================================================================
// avtf_serial_div
// Restoring divider: running sum over fill count, one quotient bit a cycle,
// result truncated toward zero.
// ============================================================================
module avtf_serial_div #(
    parameter int SUM_W = 19,
    parameter int CNT_W = 3
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic signed [SUM_W-1:0]           dividend,
    input  logic        [CNT_W-1:0]           divisor,
    output logic signed [avtf_pkg::AVG_W-1:0] quotient,
    output avtf_pkg::avtf_unit_status_t       status
);
    import avtf_pkg::*;

    localparam int STEP_W = $clog2(SUM_W + 1);

    logic [SUM_W-1:0]  quo_reg;
    logic [CNT_W-1:0]  rem_reg;
    logic [CNT_W-1:0]  div_reg;
    logic              neg_reg;
    logic [STEP_W-1:0] step_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [SUM_W-1:0]  magnitude;
    logic [CNT_W:0]    trial;
    logic [CNT_W:0]    trial_diff;
    logic              fits;
    logic [SUM_W-1:0]  signed_quo;

    assign magnitude  = dividend[SUM_W-1] ? (~dividend + 1'b1) : dividend;
    assign trial      = {rem_reg, quo_reg[SUM_W-1]};
    assign trial_diff = trial - {1'b0, div_reg};
    assign fits       = (trial >= {1'b0, div_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            step_reg <= STEP_W'(SUM_W);
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg - 1'b1;
            if (step_reg == STEP_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= magnitude;
            rem_reg <= '0;
            div_reg <= divisor;
            neg_reg <= dividend[SUM_W-1];
        end
        else if (busy_reg)
        begin
            // The remainder stays below the divisor, so it fits in CNT_W bits.
            rem_reg <= fits ? trial_diff[CNT_W-1:0] : trial[CNT_W-1:0];
            quo_reg <= {quo_reg[SUM_W-2:0], fits};
        end
    end

    assign signed_quo  = neg_reg ? (~quo_reg + 1'b1) : quo_reg;
    assign quotient    = signed_quo[AVG_W-1:0];
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

@@ design/avtf_checker.sv @@
// ============================================================================
// avtf_checker
// Port-level checks of the averaged temperature fan level unit, bound to
// the top level.
// ============================================================================
`include "averaged_temperature_fan_level_unit_assert.svh"

module avtf_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [avtf_pkg::OUT_TDATA_W-1:0] m_tdata
);
    import avtf_pkg::*;

    logic [LEVEL_W-1:0] level_seen;
    logic [MASK_W-1:0]  mask_seen;
    logic [MASK_W-1:0]  mask_expected;

    assign level_seen = m_tdata[LEVEL_W-1:0];
    assign mask_seen  = m_tdata[LEVEL_W+MASK_W-1:LEVEL_W];

    always_comb
    begin
        for (int i = 0; i < MASK_W; i++)
        begin
            mask_expected[i] = (LEVEL_W'(i) < level_seen);
        end
    end

    // A stalled result holds.
    `AVTF_ASSERT_NEXT(a_result_holds, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // The level never passes the number of threshold registers.
    `AVTF_ASSERT_SAME(a_level_range, clk, rst_n, m_tvalid, level_seen <= LEVEL_W'(LIMIT_REGS))

    // The stage mask always matches the reported level.
    `AVTF_ASSERT_SAME(a_mask_matches, clk, rst_n, m_tvalid, mask_seen == mask_expected)

    // In the cycle after a sample is accepted, s_tready is low.
    `AVTF_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, s_tvalid && s_tready, !s_tready)

endmodule

bind averaged_temperature_fan_level_unit avtf_checker u_avtf_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
// ============================================================================
// tb_top
// Self-checking bench for the averaged temperature fan level unit. Samples go
// in on the s_ stream, results are checked against a level and average
// predictor kept inside the bench, and thresholds are reprogrammed between
// phases while the unit is idle.
// ============================================================================
module tb_top;

    import avtf_pkg::*;

    localparam int HISTORY_DEPTH = DEFAULT_HISTORY_DEPTH;
    localparam int LEVEL_COUNT   = DEFAULT_LEVEL_COUNT;
    // Highest level the ladder can reach: one register per level above zero.
    localparam int TOP_LEVEL     = (LEVEL_COUNT - 1 > LIMIT_REGS) ? LIMIT_REGS
                                                                  : LEVEL_COUNT - 1;
    localparam realtime RUN_LIMIT = 10ms;
    // The longest wait for a result comes with a full climb and fall of the level ladder.
    localparam int DRAIN_CYCLES  = 60;

    localparam logic [CFG_INDEX_W-1:0] FIRST_UNMAPPED_INDEX = REG_LEVEL5_LIMITS + 1'b1;
    localparam logic [CFG_INDEX_W-1:0] LAST_CFG_INDEX       = '1;
    localparam logic [CFG_INDEX_W-1:0] LIMIT_INDEX [LIMIT_REGS] = '{
        REG_LEVEL1_LIMITS, REG_LEVEL2_LIMITS, REG_LEVEL3_LIMITS,
        REG_LEVEL4_LIMITS, REG_LEVEL5_LIMITS
    };

    // Result layout, last field in the lowest bits of m_tdata.
    typedef struct packed {
        logic signed [AVG_W-1:0] average;
        logic [MASK_W-1:0]       stage_mask;
        logic [LEVEL_W-1:0]      level;
    } fan_result_t;

    typedef enum logic {WALK_NEAR_LIMITS, FULL_RANGE} sample_style_t;

    // ------------------------------------------------------------------------
    // Clock, reset and ports. Every input starts at a known value.
    // ------------------------------------------------------------------------
    logic                    clk;
    logic                    rst_n     = 1'b0;
    logic                    s_tvalid  = 1'b0;
    logic                    s_tready;
    logic [IN_TDATA_W-1:0]   s_tdata   = '0;
    logic                    m_tvalid;
    logic                    m_tready  = 1'b1;
    logic [OUT_TDATA_W-1:0]  m_tdata;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [CFG_INDEX_W-1:0]  cfg_index = '0;
    logic [LIMIT_W-1:0]      cfg_data  = '0;

    averaged_temperature_fan_level_unit #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .LEVEL_COUNT   (LEVEL_COUNT)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Bench state: the samples waiting to be sent, the results the unit owes
    // us, and a private copy of the unit's history, level and thresholds.
    // ------------------------------------------------------------------------
    logic [IN_TDATA_W-1:0]   pending_samples[$];
    fan_result_t             expected_fan_results[$];
    int                      mismatch_count = 0;
    int                      samples_taken  = 0;
    int                      idle_pct       = 0;

    logic [LIMIT_W-1:0]      model_limits [LIMIT_REGS] = '{default: '0};
    logic [LIMIT_W-1:0]      staged_limits [LIMIT_REGS];
    logic signed [SAMPLE_W-1:0] history [HISTORY_DEPTH] = '{default: '0};
    int                      history_pos   = 0;
    int                      history_fill  = 0;
    longint                  history_sum   = 0;
    int                      fan_level     = 0;

    task automatic log_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        mismatch_count++;
    endtask

    // Appends one sample to the send queue.
    function automatic void enqueue_sample(input logic [IN_TDATA_W-1:0] sample);
        pending_samples = {pending_samples, sample};
    endfunction

    function automatic longint on_threshold(input int level);
        return longint'($signed(model_limits[level-1][31:16]));
    endfunction

    function automatic longint off_threshold(input int level);
        return longint'($signed(model_limits[level-1][15:0]));
    endfunction

    // Stores one sample in the history, then runs the climb loop followed by
    // the drop loop. Both compare the sum against threshold times fill count,
    // so no rounding of the mean ever enters the level decision.
    function automatic fan_result_t predict_fan_result(input logic signed [SAMPLE_W-1:0] sample);
        fan_result_t result;
        longint      fill;
        int          level;
        if (history_fill < HISTORY_DEPTH)
            history_fill++;
        else
            history_sum -= history[history_pos];
        history[history_pos] = sample;
        history_sum += sample;
        history_pos = (history_pos + 1) % HISTORY_DEPTH;

        fill  = history_fill;
        level = (fan_level > TOP_LEVEL) ? TOP_LEVEL : fan_level;
        while (level + 1 <= TOP_LEVEL && history_sum > on_threshold(level + 1) * fill)
            level++;
        while (level >= 1 && history_sum < off_threshold(level) * fill)
            level--;
        fan_level = level;

        result.level      = LEVEL_W'(level);
        result.stage_mask = MASK_W'((1 << level) - 1);
        // Signed division truncates toward zero, as the unit does.
        result.average    = AVG_W'(history_sum / fill);
        return result;
    endfunction

    // ------------------------------------------------------------------------
    // Sample driver. Works on the falling edge. A presented sample is held
    // until its transaction completes; between transactions the driver may
    // open an idle burst.
    // ------------------------------------------------------------------------
    int sender_gap    = 0;
    int samples_seen  = 0;

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!(s_tvalid && samples_taken == samples_seen))
            begin
                samples_seen = samples_taken;
                if (sender_gap > 0)
                begin
                    s_tvalid <= 1'b0;
                    sender_gap--;
                end
                else if (idle_pct != 0 && $urandom_range(99) < idle_pct)
                begin
                    s_tvalid   <= 1'b0;
                    sender_gap = $urandom_range(6, 0);
                end
                else if (pending_samples.size() != 0)
                begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= pending_samples[0];
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result side back-pressure, also on the falling edge: m_tready drops in
    // random bursts.
    // ------------------------------------------------------------------------
    int receiver_stall = 0;

    always @(negedge clk)
    begin
        if (receiver_stall > 0)
        begin
            m_tready <= 1'b0;
            receiver_stall--;
        end
        else if (idle_pct != 0 && $urandom_range(99) < idle_pct)
        begin
            m_tready       <= 1'b0;
            receiver_stall = $urandom_range(6, 0);
        end
        else
            m_tready <= 1'b1;
    end

    // ------------------------------------------------------------------------
    // Monitor. On the rising edge it checks each completed result transaction
    // against the oldest prediction, and turns each completed sample
    // transaction into a new prediction.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        fan_result_t observed;
        fan_result_t predicted;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                observed = m_tdata;
                if (expected_fan_results.size() == 0)
                    log_mismatch($sformatf("result %h arrived with nothing outstanding",
                                           m_tdata));
                else
                begin
                    predicted = expected_fan_results.pop_front();
                    if (observed.level !== predicted.level)
                        log_mismatch($sformatf("fan level got %0d expected %0d",
                                               observed.level, predicted.level));
                    if (observed.stage_mask !== predicted.stage_mask)
                        log_mismatch($sformatf("fan_stage_mask got %b expected %b",
                                               observed.stage_mask, predicted.stage_mask));
                    if (observed.average !== predicted.average)
                        log_mismatch($sformatf("average_temperature got %0d expected %0d",
                                               observed.average, predicted.average));
                end
            end
            if (s_tvalid && s_tready)
            begin
                predicted            = predict_fan_result(pending_samples.pop_front());
                expected_fan_results = {expected_fan_results, predicted};
                samples_taken++;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------------

    // Returns on a falling edge once every sample has been sent and answered,
    // so the unit is idle and thresholds may be changed.
    task automatic wait_until_drained();
        do
            @(negedge clk);
        while (pending_samples.size() != 0 || expected_fan_results.size() != 0);
    endtask

    // One configuration transaction. cfg_valid stays high for a following
    // write; the caller lowers it after the last one.
    task automatic write_register(input logic [CFG_INDEX_W-1:0] index,
                                  input logic [LIMIT_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (index < LIMIT_REGS)
            model_limits[index] = value;
    endtask

    // Writes all staged thresholds, then one write to an unmapped index that
    // the unit has to ignore.
    task automatic program_levels();
        for (int n = 0; n < LIMIT_REGS; n++)
            write_register(LIMIT_INDEX[n], staged_limits[n]);
        write_register(CFG_INDEX_W'($urandom_range(LAST_CFG_INDEX, FIRST_UNMAPPED_INDEX)),
                       $urandom);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // An ordered ladder: on thresholds rise by step per level and each off
    // threshold sits hyst below its on threshold.
    task automatic stage_ladder(input int base, input int step, input int hyst);
        int on_t;
        for (int n = 1; n <= LIMIT_REGS; n++)
        begin
            on_t = base + n * step;
            staged_limits[n-1] = {16'(on_t), 16'(on_t - hyst)};
        end
    endtask

    // Queues count samples. The walk style drifts through the band that
    // holds the thresholds, with occasional jumps and some full-range noise;
    // the full style draws any 16-bit value with the extremes favored.
    task automatic queue_samples(input int count, input sample_style_t style,
                                 input int band_lo, input int band_hi);
        int walk;
        int pick;
        logic [IN_TDATA_W-1:0] sample;
        walk = (band_lo + band_hi) / 2;
        @(posedge clk);
        repeat (count)
        begin
            pick = $urandom_range(99);
            if (pick < 12 && (style == FULL_RANGE || pick < 4))
                sample = pick[0] ? 16'h7FFF : 16'h8000;
            else if (style == FULL_RANGE || pick < 12)
                sample = 16'($urandom);
            else
            begin
                if (pick < 22)
                    walk = band_lo + int'($urandom_range(band_hi - band_lo));
                walk += int'($urandom_range(80)) - 40;
                if (walk > 32767)
                    walk = 32767;
                if (walk < -32768)
                    walk = -32768;
                sample = 16'(walk);
            end
            enqueue_sample(sample);
        end
    endtask

    // ------------------------------------------------------------------------
    // Test sequence.
    // ------------------------------------------------------------------------
    initial
    begin
        int base;
        int step;
        int count;
        int band_lo;
        int band_hi;
        sample_style_t style;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: the history fills up and wraps with all thresholds still
        // at their reset value of zero, including both sample extremes.
        @(posedge clk);
        enqueue_sample(16'h7FFF);
        enqueue_sample(16'h8000);
        enqueue_sample(16'h7FFF);
        enqueue_sample(16'h0000);
        enqueue_sample(16'hFFFF);
        enqueue_sample(16'h0001);
        wait_until_drained();

        // Directed: a fixed ladder. A mean equal to the first on threshold
        // must not climb, one just above it must. Then a run of maximum
        // samples sweeps to the top level and a run of minimum samples
        // sweeps all the way back down.
        stage_ladder(0, 160, 32);
        program_levels();
        @(posedge clk);
        repeat (5) enqueue_sample(16'd160);
        repeat (3) enqueue_sample(16'd161);
        repeat (5) enqueue_sample(16'h7FFF);
        repeat (5) enqueue_sample(16'h8000);

        // Random phases. Each one waits for the unit to drain, which also
        // makes the sender pause until every result is in, then reprograms
        // all levels and sends a batch of samples.
        for (int phase = 0; phase < 9; phase++)
        begin
            wait_until_drained();
            style   = WALK_NEAR_LIMITS;
            count   = 25;
            band_lo = -200;
            band_hi = 200;
            case (phase)
                0, 1, 7, 8:
                begin
                    base = int'($urandom_range(2400)) - 800;
                    step = $urandom_range(200, 16);
                    stage_ladder(base, step, $urandom_range(step));
                    band_lo  = base - 300;
                    band_hi  = base + LIMIT_REGS * step + 300;
                    count    = 150;
                    idle_pct = (phase == 0) ? 20 : (phase == 7) ? 30 : 0;
                end
                2:
                begin
                    // Unordered thresholds from random words.
                    foreach (staged_limits[n])
                        staged_limits[n] = $urandom;
                    style    = FULL_RANGE;
                    count    = 80;
                    idle_pct = 40;
                end
                3:
                begin
                    // On thresholds at the maximum: the level can never rise.
                    foreach (staged_limits[n])
                        staged_limits[n] = 32'h7FFF7FFF;
                    style    = FULL_RANGE;
                    idle_pct = 15;
                end
                4:
                begin
                    // Both at the minimum: climbs unless every sample is the
                    // minimum, and never drops.
                    foreach (staged_limits[n])
                        staged_limits[n] = 32'h80008000;
                    style = FULL_RANGE;
                end
                5:
                begin
                    foreach (staged_limits[n])
                        staged_limits[n] = 32'hFFFFFFFF;
                end
                default:
                begin
                    // Inverted hysteresis on alternate levels: a level gained by a
                    // climb can be lost again by the drop loop for the same sample.
                    foreach (staged_limits[n])
                        staged_limits[n] = n[0] ? 32'h80007FFF : 32'h7FFF8000;
                    style = FULL_RANGE;
                end
            endcase
            program_levels();
            queue_samples(count, style, band_lo, band_hi);
        end

        // The last phase ran without idling; let the final results arrive and
        // give the unit time to show any result it should not produce.
        wait_until_drained();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatch_count == 0 && expected_fan_results.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Safety net against a hung handshake.
    initial
    begin
        #(RUN_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+design
design/avtf_pkg.sv
design/avtf_history.sv
design/avtf_serial_mult.sv
design/avtf_serial_div.sv
design/averaged_temperature_fan_level_unit.sv
design/avtf_checker.sv
tb/sv/tb_top.sv
